/* hw/rtl/cts_pkg.sv */
// Shared constants for the cooperative task scheduler.
package cts_pkg;
   localparam int NUM_TASKS_DEF  = 16;
   localparam int EVENT_BITS_DEF = 8;

   typedef logic [2:0] cmd_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] slot_type;

   localparam cmd_type CMD_CREATE = 3'd0;
   localparam cmd_type CMD_YIELD  = 3'd1;
   localparam cmd_type CMD_WAIT   = 3'd2;
   localparam cmd_type CMD_WAKEUP = 3'd3;
   localparam cmd_type CMD_DELETE = 3'd4;

   localparam status_type STATUS_DONE     = 2'd0;
   localparam status_type STATUS_IGNORED  = 2'd1;
   localparam status_type STATUS_NO_WAIT  = 2'd2;

   localparam slot_type SLOT_DEAD    = 2'd0;
   localparam slot_type SLOT_READY   = 2'd1;
   localparam slot_type SLOT_RUNNING = 2'd2;
   localparam slot_type SLOT_BLOCKED = 2'd3;
endpackage

/* hw/rtl/cts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/cooperative_task_scheduler_unit.sv */
// Top level of the cooperative task scheduler.
//
// Commands arrive as transfers on the req_ channel and each one produces
// exactly one result transfer on the rsp_ channel. The ready queue and the
// wait list live in two RAMs; slot states are held in flip-flops.
// A create or a rejected command goes from ST_IDLE straight to ST_DONE; a
// yield or a wait passes through ST_SCHED, and ST_SCHED_W if a task is ready.
// Wakeup and delete scan the wait list or the ready queue one entry at a time,
// reading in ST_SCAN_RD and comparing in ST_SCAN_CHK, and then shift the tail
// down one entry at a time through ST_SHIFT_RD and ST_SHIFT_WR; the single
// read port of each RAM sets this pace. One command is in work at a time.
// A finished result sits in an output register; the next command is taken
// while it waits, and a further result waits in the machine until
// rsp_tready takes the previous one.
// Reset empties the ready queue and the wait list, marks every slot dead
// and leaves no task running. No clearing pass is needed.
module cooperative_task_scheduler_unit #(
   parameter int NUM_TASKS  = cts_pkg::NUM_TASKS_DEF,
   parameter int EVENT_BITS = cts_pkg::EVENT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // command[2:0], task_id[6:3], event_id[14:7], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // running_task[3:0], running_valid, switched,
                                   // status[7:6]
);
   import cts_pkg::*;

   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam int WW = EVENT_BITS + TW;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCHED    = 4'd1;
   localparam logic [3:0] ST_SCHED_W  = 4'd2;
   localparam logic [3:0] ST_SCAN_RD  = 4'd3;
   localparam logic [3:0] ST_SCAN_CHK = 4'd4;
   localparam logic [3:0] ST_SHIFT_RD = 4'd5;
   localparam logic [3:0] ST_SHIFT_WR = 4'd6;
   localparam logic [3:0] ST_DEL_FIN  = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [TW-1:0]         tid_ff, tid_in;
   logic [EVENT_BITS-1:0] ev_ff, ev_in;
   logic [TW-1:0]         old_slot_ff, old_slot_in;
   logic                  old_valid_ff, old_valid_in;
   status_type            status_ff, status_in;
   logic [TW-1:0]         head_ff, head_in;
   logic [CW-1:0]         rcount_ff, rcount_in;
   logic [CW-1:0]         wcount_ff, wcount_in;
   logic [TW-1:0]         cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  sel_ready_ff, sel_ready_in;
   logic [TW-1:0]         hit_ff, hit_in;
   slot_type              slot_ff [NUM_TASKS];
   slot_type              slot_in [NUM_TASKS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic                  r_we, w_we;
   logic [TW-1:0]         r_waddr, r_raddr, w_waddr, w_raddr;
   logic [TW-1:0]         r_wdata, r_rdata;
   logic [WW-1:0]         w_wdata, w_rdata;

   logic [31:0]           tid32, ev32, cur32;
   logic [TW-1:0]         req_slot;
   logic                  req_ok;
   logic [CW-1:0]         lcnt;
   logic [CW:0]           idx_next;
   logic                  match;

   function automatic logic [TW-1:0] fifo_pos(input logic [TW-1:0] head,
                                              input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(head) + (CW+1)'(k);
      if (s >= (CW+1)'(NUM_TASKS)) begin
         s = s - (CW+1)'(NUM_TASKS);
      end
      return s[TW-1:0];
   endfunction

   cts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_ready_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   cts_ram #(.WIDTH(WW), .DEPTH(NUM_TASKS)) u_wait_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   assign tid32      = {28'd0, req_tdata[6:3]};
   assign ev32       = {24'd0, req_tdata[14:7]};
   assign cur32      = 32'(cur_ff);
   assign req_slot   = tid32[TW-1:0];
   assign req_ok     = tid32 < 32'(NUM_TASKS);
   assign lcnt       = sel_ready_ff ? rcount_ff : wcount_ff;
   assign idx_next   = (CW+1)'(idx_ff) + (CW+1)'(1);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tid_in       = tid_ff;
      ev_in        = ev_ff;
      old_slot_in  = old_slot_ff;
      old_valid_in = old_valid_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      rcount_in    = rcount_ff;
      wcount_in    = wcount_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      sel_ready_in = sel_ready_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      r_we = 1'b0;  r_waddr = '0;  r_wdata = '0;  r_raddr = '0;
      w_we = 1'b0;  w_waddr = '0;  w_wdata = '0;  w_raddr = '0;
      if (sel_ready_ff) begin
         match = (r_rdata == tid_ff);
      end else if (cmd_ff == CMD_WAKEUP) begin
         match = (w_rdata[WW-1:TW] == ev_ff);
      end else begin
         match = (w_rdata[TW-1:0] == tid_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = req_tdata[2:0];
               tid_in       = req_slot;
               ev_in        = ev32[EVENT_BITS-1:0];
               old_slot_in  = cur_ff;
               old_valid_in = cur_valid_ff;
               status_in    = STATUS_DONE;
               idx_in       = '0;
               state_in     = ST_DONE;
               unique case (req_tdata[2:0])
                  CMD_CREATE: begin
                     if (!req_ok || slot_ff[req_slot] != SLOT_DEAD) begin
                        status_in = STATUS_IGNORED;
                     end else begin
                        slot_in[req_slot] = SLOT_READY;
                        r_we      = 1'b1;
                        r_waddr   = fifo_pos(head_ff, rcount_ff);
                        r_wdata   = req_slot;
                        rcount_in = rcount_ff + CW'(1);
                     end
                  end
                  CMD_YIELD: begin
                     state_in = ST_SCHED;
                  end
                  CMD_WAIT: begin
                     if (!cur_valid_ff) begin
                        status_in = STATUS_IGNORED;
                     end else begin
                        slot_in[cur_ff] = SLOT_BLOCKED;
                        w_we         = 1'b1;
                        w_waddr      = wcount_ff[TW-1:0];
                        w_wdata      = {ev32[EVENT_BITS-1:0], cur_ff};
                        wcount_in    = wcount_ff + CW'(1);
                        cur_valid_in = 1'b0;
                        cur_in       = '0;
                        state_in     = ST_SCHED;
                     end
                  end
                  CMD_WAKEUP: begin
                     status_in    = STATUS_NO_WAIT;
                     sel_ready_in = 1'b0;
                     state_in     = ST_SCAN_RD;
                  end
                  CMD_DELETE: begin
                     if (!req_ok || slot_ff[req_slot] == SLOT_DEAD) begin
                        status_in = STATUS_IGNORED;
                     end else if (slot_ff[req_slot] == SLOT_READY) begin
                        sel_ready_in = 1'b1;
                        state_in     = ST_SCAN_RD;
                     end else if (slot_ff[req_slot] == SLOT_BLOCKED) begin
                        sel_ready_in = 1'b0;
                        state_in     = ST_SCAN_RD;
                     end else begin
                        state_in = ST_DEL_FIN;
                     end
                  end
                  default: begin
                     status_in = STATUS_IGNORED;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == lcnt) begin
               state_in = (cmd_ff == CMD_WAKEUP) ? ST_DONE : ST_DEL_FIN;
            end else begin
               r_raddr  = fifo_pos(head_ff, idx_ff);
               w_raddr  = idx_ff[TW-1:0];
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (match) begin
               hit_in   = sel_ready_ff ? r_rdata : w_rdata[TW-1:0];
               state_in = ST_SHIFT_RD;
            end else begin
               idx_in   = idx_next[CW-1:0];
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_next >= (CW+1)'(lcnt)) begin
               if (sel_ready_ff) begin
                  rcount_in = rcount_ff - CW'(1);
                  state_in  = ST_DEL_FIN;
               end else begin
                  wcount_in = wcount_ff - CW'(1);
                  if (cmd_ff == CMD_WAKEUP) begin
                     status_in       = STATUS_DONE;
                     slot_in[hit_ff] = SLOT_READY;
                     r_we            = 1'b1;
                     r_waddr         = fifo_pos(head_ff, rcount_ff);
                     r_wdata         = hit_ff;
                     rcount_in       = rcount_ff + CW'(1);
                     state_in        = ST_SCHED;
                  end else begin
                     state_in = ST_DEL_FIN;
                  end
               end
            end else begin
               r_raddr  = fifo_pos(head_ff, idx_next[CW-1:0]);
               w_raddr  = idx_next[TW-1:0];
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            if (sel_ready_ff) begin
               r_we    = 1'b1;
               r_waddr = fifo_pos(head_ff, idx_ff);
               r_wdata = r_rdata;
            end else begin
               w_we    = 1'b1;
               w_waddr = idx_ff[TW-1:0];
               w_wdata = w_rdata;
            end
            idx_in   = idx_next[CW-1:0];
            state_in = ST_SHIFT_RD;
         end
         ST_DEL_FIN: begin
            slot_in[tid_ff] = SLOT_DEAD;
            if (cur_valid_ff && cur_ff == tid_ff) begin
               cur_valid_in = 1'b0;
               cur_in       = '0;
            end
            state_in = ST_SCHED;
         end
         ST_SCHED: begin
            if (rcount_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               r_raddr  = head_ff;
               state_in = ST_SCHED_W;
            end
         end
         ST_SCHED_W: begin
            head_in = (32'(head_ff) == NUM_TASKS - 1) ? '0 : head_ff + TW'(1);
            if (cur_valid_ff) begin
               slot_in[cur_ff] = SLOT_READY;
               r_we    = 1'b1;
               r_waddr = fifo_pos(head_ff, rcount_ff);
               r_wdata = cur_ff;
            end else begin
               rcount_in = rcount_ff - CW'(1);
            end
            slot_in[r_rdata] = SLOT_RUNNING;
            cur_in       = r_rdata;
            cur_valid_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {status_ff,
                               (cur_valid_ff != old_valid_ff) ||
                                  (cur_valid_ff && cur_ff != old_slot_ff),
                               cur_valid_ff,
                               cur_valid_ff ? cur32[3:0] : 4'd0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         rcount_ff    <= '0;
         wcount_ff    <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            slot_ff[i] <= SLOT_DEAD;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rcount_ff    <= rcount_in;
         wcount_ff    <= wcount_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
      cmd_ff       <= cmd_in;
      tid_ff       <= tid_in;
      ev_ff        <= ev_in;
      old_slot_ff  <= old_slot_in;
      old_valid_ff <= old_valid_in;
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      sel_ready_ff <= sel_ready_in;
      hit_ff       <= hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // The ready queue and the wait list never hold more than NUM_TASKS entries each.
   assert property (@(posedge clock) disable iff (reset)
      (32'(rcount_ff) <= NUM_TASKS) && (32'(wcount_ff) <= NUM_TASKS))
      else $error("queue count overflow");

   // The current slot is always the one marked running.
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (slot_ff[cur_ff] == SLOT_RUNNING))
      else $error("current slot is not running");

   // A result never carries an undefined status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[7:6] != 2'd3))
      else $error("bad status code");

   // A new command is taken only when no command is in work.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("command accepted but machine stayed idle");
endmodule
